// ----- sv/layer_output_mse_macros.svh -----
// assertion macros shared by the layer output mse checker
`ifndef LAYER_OUTPUT_MSE_MACROS_SVH
`define LAYER_OUTPUT_MSE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LOM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("layer_output_mse check failed");

// antecedent implies consequent in the next cycle
`define LOM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("layer_output_mse check failed");

`endif

// ----- sv/lom_pkg.sv -----
// shared types, codes and constants of the layer output mse block
package lom_pkg;

   localparam int MAX_ROWS_DEF   = 64;
   localparam int MAX_COLS_DEF   = 64;
   localparam int MAX_TOKENS_DEF = 64;

   localparam int DIM_W     = 7;
   localparam int DIV_W     = 2 * DIM_W;
   localparam int IDX_W     = 6;
   localparam int WEIGHT_W  = 16;
   localparam int DELTA_W   = WEIGHT_W + 1;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = DELTA_W + SAMPLE_W;
   localparam int SUM_W     = 64;
   localparam int MSE_W     = 63;
   localparam int DIFF_W    = 32;
   localparam int FRAC_DROP = 14;
   localparam int ROUND_BIAS = 8192;
   localparam int PIPE_DEPTH = 8;
   localparam int DRAIN_W    = 4;

   typedef enum logic [1:0] {
      FUNC_LOAD_W  = 2'd0,
      FUNC_LOAD_X  = 2'd1,
      FUNC_COMPUTE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CSR_OUT_ROWS    = 2'd0,
      CSR_IN_COLS     = 2'd1,
      CSR_TOKEN_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic             issue;
      logic             first;
      logic             last;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] tok;
      logic [DIV_W-1:0] divisor;
      logic             div_start;
      logic             emit;
      logic             empty;
   } lom_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_valid;
   } lom_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int mx);
      logic [DIM_W-1:0] r;
      r = v;
      if (int'(v) > mx) begin
         r = DIM_W'(mx);
      end
      return r;
   endfunction

endpackage

// ----- sv/layer_output_mse.sv -----
// layer output mse: loads a weight delta matrix and a calibration matrix one element per
// transaction, then on a compute transaction returns the mean squared difference of the two
// layer outputs. Loads can follow back to back. A compute walks all
// rows x tokens x columns products through one shared multiply-accumulate pipeline, one
// product per cycle, then runs a 64-step restoring divider, so it keeps req_stall high until
// the result is emitted; an empty shape skips the pipeline and the divider. The result
// sits in an output register, so a new transaction is taken while it waits for the consumer.
module layer_output_mse #(
   parameter int MAX_ROWS   = lom_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = lom_pkg::MAX_COLS_DEF,
   parameter int MAX_TOKENS = lom_pkg::MAX_TOKENS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [lom_pkg::DIM_W-1:0]     csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [lom_pkg::IDX_W-1:0]     req_first_index,
   input  logic [lom_pkg::IDX_W-1:0]     req_second_index,
   input  logic signed [lom_pkg::WEIGHT_W-1:0] req_estimate_weight,
   input  logic signed [lom_pkg::WEIGHT_W-1:0] req_reference_weight,
   input  logic signed [lom_pkg::SAMPLE_W-1:0] req_calib_sample,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lom_pkg::MSE_W-1:0]     rsp_mse_value,
   output logic                          rsp_empty_shape,
   output logic                          rsp_saturated
);
   import lom_pkg::*;

   lom_cmd_type    cmd;
   lom_status_type status;
   logic           req_accept;

   // loads write the stores only while the controller is idle
   assign req_accept = req_valid & ~req_stall;

   // sequencer: dimension registers, loop counters, drain and divide timing
   lom_ctrl #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_TOKENS (MAX_TOKENS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_func     (req_func),
      .rsp_stall    (rsp_stall),
      .status       (status),
      .cmd          (cmd),
      .req_stall    (req_stall)
   );

   // stores, mac pipeline, squared sum, divider and response register
   lom_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_TOKENS (MAX_TOKENS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_accept           (req_accept),
      .req_func             (req_func),
      .req_first_index      (req_first_index),
      .req_second_index     (req_second_index),
      .req_estimate_weight  (req_estimate_weight),
      .req_reference_weight (req_reference_weight),
      .req_calib_sample     (req_calib_sample),
      .cmd                  (cmd),
      .rsp_stall            (rsp_stall),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_mse_value        (rsp_mse_value),
      .rsp_empty_shape      (rsp_empty_shape),
      .rsp_saturated        (rsp_saturated)
   );

endmodule

// ----- sv/lom_ctrl.sv -----
// controller: configuration registers, loop counters and sequencing of a compute
module lom_ctrl #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int MAX_TOKENS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [lom_pkg::DIM_W-1:0] csr_wdata,
   input  logic                   req_valid,
   input  logic [1:0]             req_func,
   input  logic                   rsp_stall,
   input  lom_pkg::lom_status_type status,
   output lom_pkg::lom_cmd_type   cmd,
   output logic                   req_stall
);
   import lom_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_RUN, S_DRAIN, S_DIV, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   lom_cmd_type       cmd_ff, cmd_in;
   logic [DIM_W-1:0]  rows_reg_ff, rows_reg_in;
   logic [DIM_W-1:0]  cols_reg_ff, cols_reg_in;
   logic [DIM_W-1:0]  toks_reg_ff, toks_reg_in;
   logic [DIM_W-1:0]  row_ff, row_in, col_ff, col_in, tok_ff, tok_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic              empty_ff, empty_in;
   logic [DIM_W-1:0]  rows, cols, toks;
   logic              row_last, col_last, tok_last, rsp_free;

   assign rows = clamp_dim(rows_reg_ff, MAX_ROWS);
   assign cols = clamp_dim(cols_reg_ff, MAX_COLS);
   assign toks = clamp_dim(toks_reg_ff, MAX_TOKENS);

   assign row_last = (row_ff == rows - DIM_W'(1));
   assign col_last = (col_ff == cols - DIM_W'(1));
   assign tok_last = (tok_ff == toks - DIM_W'(1));
   assign rsp_free = (!status.rsp_valid || !rsp_stall) && !cmd_ff.emit;

   assign req_stall = (state_ff != S_IDLE);
   assign cmd       = cmd_ff;

   always_comb begin
      state_in    = state_ff;
      rows_reg_in = rows_reg_ff;
      cols_reg_in = cols_reg_ff;
      toks_reg_in = toks_reg_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      tok_in      = tok_ff;
      drain_in    = drain_ff;
      empty_in    = empty_ff;
      cmd_in           = '0;
      cmd_in.row       = row_ff;
      cmd_in.col       = col_ff;
      cmd_in.tok       = tok_ff;
      cmd_in.divisor   = cmd_ff.divisor;
      cmd_in.empty     = empty_ff;

      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_OUT_ROWS:    rows_reg_in = csr_wdata;
            CSR_IN_COLS:     cols_reg_in = csr_wdata;
            CSR_TOKEN_COUNT: toks_reg_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && func_type'(req_func) == FUNC_COMPUTE) begin
               if (rows == '0 || cols == '0 || toks == '0) begin
                  empty_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  empty_in       = 1'b0;
                  cmd_in.start   = 1'b1;
                  cmd_in.divisor = DIV_W'(rows) * DIV_W'(toks);
                  row_in   = '0;
                  col_in   = '0;
                  tok_in   = '0;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            cmd_in.issue = 1'b1;
            cmd_in.first = (col_ff == '0);
            cmd_in.last  = col_last;
            if (!col_last) begin
               col_in = col_ff + DIM_W'(1);
            end else begin
               col_in = '0;
               if (!tok_last) begin
                  tok_in = tok_ff + DIM_W'(1);
               end else begin
                  tok_in = '0;
                  if (!row_last) begin
                     row_in = row_ff + DIM_W'(1);
                  end else begin
                     drain_in = '0;
                     state_in = S_DRAIN;
                  end
               end
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_ff == DRAIN_W'(PIPE_DEPTH - 1)) begin
               cmd_in.div_start = 1'b1;
               state_in         = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               cmd_in.emit = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cmd_ff      <= '0;
         rows_reg_ff <= '0;
         cols_reg_ff <= '0;
         toks_reg_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         tok_ff      <= '0;
         drain_ff    <= '0;
         empty_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cmd_ff      <= cmd_in;
         rows_reg_ff <= rows_reg_in;
         cols_reg_ff <= cols_reg_in;
         toks_reg_ff <= toks_reg_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         tok_ff      <= tok_in;
         drain_ff    <= drain_in;
         empty_ff    <= empty_in;
      end
   end

endmodule

// ----- sv/lom_dp.sv -----
// datapath: stores, multiply-accumulate pipeline, squared sum, divider, result register
module lom_dp #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int MAX_TOKENS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  logic [1:0]                    req_func,
   input  logic [lom_pkg::IDX_W-1:0]     req_first_index,
   input  logic [lom_pkg::IDX_W-1:0]     req_second_index,
   input  logic signed [lom_pkg::WEIGHT_W-1:0] req_estimate_weight,
   input  logic signed [lom_pkg::WEIGHT_W-1:0] req_reference_weight,
   input  logic signed [lom_pkg::SAMPLE_W-1:0] req_calib_sample,
   input  lom_pkg::lom_cmd_type          cmd,
   input  logic                          rsp_stall,
   output lom_pkg::lom_status_type       status,
   output logic                          rsp_valid,
   output logic [lom_pkg::MSE_W-1:0]     rsp_mse_value,
   output logic                          rsp_empty_shape,
   output logic                          rsp_saturated
);
   import lom_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int TW    = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
   localparam int ACC_W = PROD_W + $clog2(MAX_COLS) + 1;
   localparam int SH_W  = ACC_W + 1 - FRAC_DROP;
   localparam int CNT_W = $clog2(SUM_W);
   localparam logic signed [SUM_W-1:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] I32_MIN = -64'sh0000_0000_8000_0000;

   logic signed [DELTA_W-1:0]  wmem [2**(RW+CW)];
   logic signed [SAMPLE_W-1:0] xmem [2**(CW+TW)];

   logic signed [DELTA_W-1:0]  w_rd_ff;
   logic signed [SAMPLE_W-1:0] x_rd_ff;
   logic                       iss1_ff, first1_ff, last1_ff;
   logic                       iss2_ff, first2_ff, last2_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       fin3_ff, fin4_ff, fin5_ff;
   logic signed [DIFF_W-1:0]   rnd_ff;
   logic [SUM_W-1:0]           sq_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic                       sat_ff;
   logic [DIV_W-1:0]           divisor_ff;

   logic [SUM_W-1:0]           quo_ff;
   logic [DIV_W-1:0]           rem_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       div_busy_ff, div_done_ff;

   logic                       rsp_valid_ff;
   logic [MSE_W-1:0]           mse_ff;
   logic                       empty_ff, rsp_sat_ff;

   logic signed [ACC_W:0]      biased;
   logic signed [SH_W-1:0]     shifted;
   logic signed [SUM_W-1:0]    wide;
   logic signed [DIFF_W-1:0]   rnd_in;
   logic                       rnd_sat;
   logic [DIFF_W-1:0]          mag;
   logic [SUM_W:0]             sum_ext;
   logic [DIV_W:0]             rem_sh;
   logic                       qbit;
   logic [DIV_W-1:0]           rem_next;
   logic                       load_w_ok, load_x_ok;

   // loads
   assign load_w_ok = req_accept && func_type'(req_func) == FUNC_LOAD_W &&
                      int'(req_first_index) < MAX_ROWS && int'(req_second_index) < MAX_COLS;
   assign load_x_ok = req_accept && func_type'(req_func) == FUNC_LOAD_X &&
                      int'(req_first_index) < MAX_COLS && int'(req_second_index) < MAX_TOKENS;

   always_ff @(posedge clock) begin
      if (load_w_ok) begin
         wmem[{RW'(req_first_index), CW'(req_second_index)}] <=
            DELTA_W'(req_estimate_weight) - DELTA_W'(req_reference_weight);
      end
      w_rd_ff <= wmem[{RW'(cmd.row), CW'(cmd.col)}];
   end

   always_ff @(posedge clock) begin
      if (load_x_ok) begin
         xmem[{CW'(req_first_index), TW'(req_second_index)}] <= req_calib_sample;
      end
      x_rd_ff <= xmem[{CW'(cmd.col), TW'(cmd.tok)}];
   end

   // round half up to q.8, saturate to 32 bits
   always_comb begin
      biased  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(ROUND_BIAS);
      shifted = SH_W'(biased >>> FRAC_DROP);
      wide    = SUM_W'(shifted);
      rnd_sat = 1'b0;
      rnd_in  = DIFF_W'(wide);
      if (wide > I32_MAX) begin
         rnd_in  = DIFF_W'(I32_MAX);
         rnd_sat = 1'b1;
      end else if (wide < I32_MIN) begin
         rnd_in  = DIFF_W'(I32_MIN);
         rnd_sat = 1'b1;
      end
   end

   assign mag     = rnd_ff[DIFF_W-1] ? DIFF_W'(-rnd_ff) : DIFF_W'(rnd_ff);
   assign sum_ext = {1'b0, sum_ff} + {1'b0, sq_ff};

   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign qbit     = (rem_sh >= {1'b0, divisor_ff});
   assign rem_next = qbit ? DIV_W'(rem_sh - {1'b0, divisor_ff}) : DIV_W'(rem_sh);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(w_rd_ff) * PROD_W'(x_rd_ff);
      if (iss2_ff) begin
         acc_ff <= first2_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
      if (fin3_ff) begin
         rnd_ff <= rnd_in;
      end
      sq_ff <= SUM_W'(mag) * SUM_W'(mag);
      if (cmd.start) begin
         divisor_ff <= cmd.divisor;
      end
      if (cmd.div_start) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
      end else if (div_busy_ff) begin
         quo_ff <= {quo_ff[SUM_W-2:0], qbit};
         rem_ff <= rem_next;
      end
      if (cmd.emit) begin
         if (cmd.empty) begin
            mse_ff     <= '0;
            empty_ff   <= 1'b1;
            rsp_sat_ff <= 1'b0;
         end else begin
            mse_ff     <= quo_ff[SUM_W-1] ? '1 : quo_ff[MSE_W-1:0];
            empty_ff   <= 1'b0;
            rsp_sat_ff <= sat_ff | quo_ff[SUM_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss1_ff      <= 1'b0;
         first1_ff    <= 1'b0;
         last1_ff     <= 1'b0;
         iss2_ff      <= 1'b0;
         first2_ff    <= 1'b0;
         last2_ff     <= 1'b0;
         fin3_ff      <= 1'b0;
         fin4_ff      <= 1'b0;
         fin5_ff      <= 1'b0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         cnt_ff       <= '0;
         div_busy_ff  <= 1'b0;
         div_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss1_ff   <= cmd.issue;
         first1_ff <= cmd.first;
         last1_ff  <= cmd.last;
         iss2_ff   <= iss1_ff;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         fin3_ff   <= iss2_ff & last2_ff;
         fin4_ff   <= fin3_ff;
         fin5_ff   <= fin4_ff;
         if (cmd.start) begin
            sum_ff <= '0;
            sat_ff <= 1'b0;
         end else begin
            if (fin3_ff && rnd_sat) begin
               sat_ff <= 1'b1;
            end
            if (fin5_ff) begin
               if (sum_ext[SUM_W]) begin
                  sum_ff <= '1;
                  sat_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_ext[SUM_W-1:0];
               end
            end
         end
         div_done_ff <= 1'b0;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
            cnt_ff      <= '0;
         end else if (div_busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
         rsp_valid_ff <= cmd.emit | (rsp_valid_ff & rsp_stall);
      end
   end

   assign status.div_done  = div_done_ff;
   assign status.rsp_valid = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mse_value    = mse_ff;
   assign rsp_empty_shape  = empty_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

// ----- sv/lom_checker.sv -----
// port-level checker for the layer output mse block and its bind
`include "layer_output_mse_macros.svh"

module lom_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_func,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lom_pkg::MSE_W-1:0]     rsp_mse_value,
   input logic                          rsp_empty_shape,
   input logic                          rsp_saturated
);
   import lom_pkg::*;

   // a compute transaction makes the block busy
   `LOM_ASSERT_NEXT(a_compute_busy, clock, reset, req_valid && !req_stall && req_func == FUNC_COMPUTE, req_stall)
   // empty shape forces a zero, unsaturated result
   `LOM_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_empty_shape, rsp_mse_value == '0 && !rsp_saturated)
   // a stalled response stays
   `LOM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // and keeps its value
   `LOM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_mse_value))

endmodule

bind layer_output_mse lom_checker u_lom_checker (.*);
